// File: rtl/csvp_pkg.sv
package csvp_pkg;

   localparam int WsMaxDefault = 8;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_FEND = 2'd1;
   localparam logic [1:0] KIND_REC  = 2'd2;

   localparam logic [15:0] COL_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_DATA,
      ST_FEND,
      ST_LFEND,
      ST_REC
   } step_type;

   typedef struct packed {
      logic flush;
      logic data;
      logic fend;
      logic lfend;
      logic rec;
   } plan_flags_type;

   typedef struct packed {
      plan_flags_type new_plan;
      plan_flags_type cur_plan;
   } dp_status_type;

   typedef struct packed {
      logic     accept;
      logic     emit;
      step_type step;
      logic     last;
   } ctrl_cmd_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == COL_MAX) ? v : v + 16'd1;
   endfunction

   function automatic step_type first_step(input plan_flags_type p);
      step_type s;
      if (p.flush) begin
         s = ST_FLUSH;
      end else if (p.data) begin
         s = ST_DATA;
      end else if (p.fend) begin
         s = ST_FEND;
      end else if (p.lfend) begin
         s = ST_LFEND;
      end else if (p.rec) begin
         s = ST_REC;
      end else begin
         s = ST_IDLE;
      end
      return s;
   endfunction

   function automatic step_type after_step(input step_type s, input plan_flags_type cur);
      plan_flags_type p;
      step_type       n;
      p = cur;
      p.flush = 1'b0;
      unique case (s)
         ST_FLUSH: begin
            n = cur.flush ? ST_FLUSH : first_step(p);
         end
         ST_DATA: begin
            p.data = 1'b0;
            n = first_step(p);
         end
         ST_FEND: begin
            p.data = 1'b0;
            p.fend = 1'b0;
            n = first_step(p);
         end
         ST_LFEND: begin
            p.data  = 1'b0;
            p.fend  = 1'b0;
            p.lfend = 1'b0;
            n = first_step(p);
         end
         default: begin
            n = ST_IDLE;
         end
      endcase
      return n;
   endfunction

endpackage

// File: rtl/csvp_ctrl.sv
module csvp_ctrl import csvp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   step_type state_ff, state_in;
   step_type after;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     slot_free;
   logic     emit;
   logic     done;
   logic     accept;

   always_comb begin
      slot_free = !rsp_valid_ff || !rsp_stall;
      emit      = (state_ff != ST_IDLE) && slot_free;
      after     = after_step(state_ff, status.cur_plan);
      done      = (state_ff == ST_IDLE) || (emit && (after == ST_IDLE));
      accept    = req_valid && done;
      req_stall = !done;

      cmd.accept = accept;
      cmd.emit   = emit;
      cmd.step   = state_ff;
      cmd.last   = (after == ST_IDLE);

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (slot_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      if (accept) begin
         state_in = first_step(status.new_plan);
      end else if (emit) begin
         state_in = after;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_emit_fills_slot: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted response not presented");

   a_accept_when_free: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (state_ff == ST_IDLE || (emit && cmd.last)))
      else $error("request accepted while response sequence pending");
`endif

endmodule

// File: rtl/csvp_dpath.sv
module csvp_dpath import csvp_pkg::*; #(
   parameter int WS_MAX = WsMaxDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    req_ch,
   input  logic          req_last_in_line,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output logic [1:0]    rsp_kind,
   output logic [7:0]    rsp_data_byte,
   output logic [15:0]   rsp_column_count,
   output logic          rsp_ws_overflow,
   output logic          rsp_last
);

   localparam int CW = $clog2(WS_MAX + 1);
   localparam int IW = (WS_MAX > 1) ? $clog2(WS_MAX) : 1;
   localparam logic [CW-1:0] WsMaxC = CW'(WS_MAX);

   logic          in_quote_ff, in_quote_in;
   logic          quote_pending_ff, quote_pending_in;
   logic          field_quoted_ff, field_quoted_in;
   logic          line_blank_ff, line_blank_in;
   logic          field_started_ff, field_started_in;
   logic          skip_rest_ff, skip_rest_in;
   logic [CW-1:0] pend_cnt_ff, pend_cnt_in;
   logic [15:0]   col_cnt_ff, col_cnt_in;
   logic          ovf_ff, ovf_in;

   logic [CW-1:0] flush_n_ff, flush_n_in;
   logic [IW-1:0] flush_idx_ff;
   logic          pl_data_ff, pl_data_in;
   logic          pl_fend_ff, pl_fend_in;
   logic          pl_lfend_ff, pl_lfend_in;
   logic          pl_rec_ff, pl_rec_in;
   logic [7:0]    data_ff;
   logic [15:0]   rec_cols_ff, rec_cols_in;
   logic          rec_ovf_ff, rec_ovf_in;
   logic          ws_wr;
   logic          do_plain;

   logic [7:0]    pending_ws [WS_MAX];

   logic [1:0]    rsp_kind_ff;
   logic [7:0]    rsp_data_byte_ff;
   logic [15:0]   rsp_column_count_ff;
   logic          rsp_ws_overflow_ff;
   logic          rsp_last_ff;

   always_comb begin
      in_quote_in      = in_quote_ff;
      quote_pending_in = quote_pending_ff;
      field_quoted_in  = field_quoted_ff;
      line_blank_in    = line_blank_ff;
      field_started_in = field_started_ff;
      skip_rest_in     = skip_rest_ff;
      pend_cnt_in      = pend_cnt_ff;
      col_cnt_in       = col_cnt_ff;
      ovf_in           = ovf_ff;
      flush_n_in       = '0;
      pl_data_in       = 1'b0;
      pl_fend_in       = 1'b0;
      pl_lfend_in      = 1'b0;
      pl_rec_in        = 1'b0;
      ws_wr            = 1'b0;
      do_plain         = 1'b0;

      if (!skip_rest_ff) begin
         if (quote_pending_ff) begin
            quote_pending_in = 1'b0;
            if (req_ch == CH_QUOTE) begin
               pl_data_in       = 1'b1;
               field_started_in = 1'b1;
            end else begin
               in_quote_in = 1'b0;
               do_plain    = 1'b1;
            end
         end else if (in_quote_ff) begin
            if (req_ch == CH_QUOTE) begin
               quote_pending_in = 1'b1;
            end else begin
               pl_data_in       = 1'b1;
               field_started_in = 1'b1;
            end
         end else begin
            do_plain = 1'b1;
         end
      end

      if (do_plain) begin
         if (req_ch == CH_LF || req_ch == CH_CR) begin
            skip_rest_in = 1'b1;
         end else if (req_ch == CH_QUOTE) begin
            flush_n_in      = pend_cnt_ff;
            pend_cnt_in     = '0;
            in_quote_in     = 1'b1;
            field_quoted_in = 1'b1;
            line_blank_in   = 1'b0;
         end else if (!(is_ws(req_ch) && !field_started_ff)) begin
            if (req_ch == CH_COMMA) begin
               pend_cnt_in      = '0;
               pl_fend_in       = 1'b1;
               col_cnt_in       = sat_inc(col_cnt_ff);
               field_quoted_in  = 1'b0;
               field_started_in = 1'b0;
            end else begin
               line_blank_in    = 1'b0;
               field_started_in = 1'b1;
               if (is_ws(req_ch) && !field_quoted_ff) begin
                  if (pend_cnt_ff < WsMaxC) begin
                     ws_wr       = 1'b1;
                     pend_cnt_in = pend_cnt_ff + CW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  flush_n_in  = pend_cnt_ff;
                  pend_cnt_in = '0;
                  pl_data_in  = 1'b1;
               end
            end
         end
      end

      rec_cols_in = col_cnt_in;
      rec_ovf_in  = ovf_in;
      if (req_last_in_line) begin
         if (!line_blank_in) begin
            pl_lfend_in = 1'b1;
            rec_cols_in = sat_inc(col_cnt_in);
         end
         pl_rec_in        = 1'b1;
         in_quote_in      = 1'b0;
         quote_pending_in = 1'b0;
         field_quoted_in  = 1'b0;
         line_blank_in    = 1'b1;
         field_started_in = 1'b0;
         skip_rest_in     = 1'b0;
         pend_cnt_in      = '0;
         col_cnt_in       = '0;
         ovf_in           = 1'b0;
      end
   end

   always_comb begin
      status.new_plan.flush = (flush_n_in != '0);
      status.new_plan.data  = pl_data_in;
      status.new_plan.fend  = pl_fend_in;
      status.new_plan.lfend = pl_lfend_in;
      status.new_plan.rec   = pl_rec_in;
      status.cur_plan.flush = ((CW'(flush_idx_ff) + CW'(1)) < flush_n_ff);
      status.cur_plan.data  = pl_data_ff;
      status.cur_plan.fend  = pl_fend_ff;
      status.cur_plan.lfend = pl_lfend_ff;
      status.cur_plan.rec   = pl_rec_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quote_ff      <= 1'b0;
         quote_pending_ff <= 1'b0;
         field_quoted_ff  <= 1'b0;
         line_blank_ff    <= 1'b1;
         field_started_ff <= 1'b0;
         skip_rest_ff     <= 1'b0;
         pend_cnt_ff      <= '0;
         col_cnt_ff       <= '0;
         ovf_ff           <= 1'b0;
         flush_n_ff       <= '0;
         flush_idx_ff     <= '0;
         pl_data_ff       <= 1'b0;
         pl_fend_ff       <= 1'b0;
         pl_lfend_ff      <= 1'b0;
         pl_rec_ff        <= 1'b0;
      end else if (cmd.accept) begin
         in_quote_ff      <= in_quote_in;
         quote_pending_ff <= quote_pending_in;
         field_quoted_ff  <= field_quoted_in;
         line_blank_ff    <= line_blank_in;
         field_started_ff <= field_started_in;
         skip_rest_ff     <= skip_rest_in;
         pend_cnt_ff      <= pend_cnt_in;
         col_cnt_ff       <= col_cnt_in;
         ovf_ff           <= ovf_in;
         flush_n_ff       <= flush_n_in;
         flush_idx_ff     <= '0;
         pl_data_ff       <= pl_data_in;
         pl_fend_ff       <= pl_fend_in;
         pl_lfend_ff      <= pl_lfend_in;
         pl_rec_ff        <= pl_rec_in;
      end else if (cmd.emit && cmd.step == ST_FLUSH) begin
         flush_idx_ff <= flush_idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         data_ff     <= req_ch;
         rec_cols_ff <= rec_cols_in;
         rec_ovf_ff  <= rec_ovf_in;
      end
      if (cmd.accept && ws_wr) begin
         pending_ws[pend_cnt_ff[IW-1:0]] <= req_ch;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_last_ff <= cmd.last;
         unique case (cmd.step) inside
            ST_FLUSH: begin
               rsp_kind_ff         <= KIND_DATA;
               rsp_data_byte_ff    <= pending_ws[flush_idx_ff];
               rsp_column_count_ff <= '0;
               rsp_ws_overflow_ff  <= 1'b0;
            end
            ST_DATA: begin
               rsp_kind_ff         <= KIND_DATA;
               rsp_data_byte_ff    <= data_ff;
               rsp_column_count_ff <= '0;
               rsp_ws_overflow_ff  <= 1'b0;
            end
            ST_FEND, ST_LFEND: begin
               rsp_kind_ff         <= KIND_FEND;
               rsp_data_byte_ff    <= '0;
               rsp_column_count_ff <= '0;
               rsp_ws_overflow_ff  <= 1'b0;
            end
            ST_REC: begin
               rsp_kind_ff         <= KIND_REC;
               rsp_data_byte_ff    <= '0;
               rsp_column_count_ff <= rec_cols_ff;
               rsp_ws_overflow_ff  <= rec_ovf_ff;
            end
            default: begin
               rsp_kind_ff         <= KIND_DATA;
               rsp_data_byte_ff    <= '0;
               rsp_column_count_ff <= '0;
               rsp_ws_overflow_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_kind         = rsp_kind_ff;
   assign rsp_data_byte    = rsp_data_byte_ff;
   assign rsp_column_count = rsp_column_count_ff;
   assign rsp_ws_overflow  = rsp_ws_overflow_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   a_flush_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.step == ST_FLUSH) |-> (CW'(flush_idx_ff) < flush_n_ff))
      else $error("flush index beyond held whitespace");

   a_pend_bounded: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff <= WsMaxC)
      else $error("held whitespace count exceeds buffer");

   a_rec_is_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.step == ST_REC) |=> (rsp_kind_ff == KIND_REC && rsp_last_ff))
      else $error("record end not the final response");

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_last_in_line) |=>
         (pend_cnt_ff == '0 && col_cnt_ff == '0 && line_blank_ff && !skip_rest_ff))
      else $error("line state not cleared after record end");
`endif

endmodule

// File: rtl/csv_line_field_parser_core.sv
// CSV line splitter: one byte per request, field bytes, field ends and record ends out.
// The accepted request sets the step register; each step then loads the registered response slot.
// A byte gives its responses one step each, held while the receiver stalls (a byte that gives none
//   holds no step); the next request is taken in the cycle its last response is loaded.
// Held whitespace is flushed one byte per cycle from the whitespace buffer while the receiver does not stall.
// Reset: synchronous, active high; clears line state, no warm-up pass needed.
module csv_line_field_parser_core import csvp_pkg::*; #(
   parameter int WS_MAX = WsMaxDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_last_in_line,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_column_count,
   output logic        rsp_ws_overflow,
   output logic        rsp_last
);

   dp_status_type status;
   ctrl_cmd_type  cmd;

   csvp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   csvp_dpath #(
      .WS_MAX (WS_MAX)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .req_last_in_line (req_last_in_line),
      .cmd              (cmd),
      .status           (status),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_column_count (rsp_column_count),
      .rsp_ws_overflow  (rsp_ws_overflow),
      .rsp_last         (rsp_last)
   );

endmodule

// File: tb/tb.sv
module tb import csvp_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WsDepth = WsMaxDefault;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [15:0] cols;
      logic        ovf;
      logic        last;
   } csv_token_type;

   typedef struct packed {
      logic [7:0]    ch;
      logic          fin;
      logic          typed;
      csv_token_type tok;
   } stim_row_type;

   localparam csv_token_type NoTok = '0;

   localparam stim_row_type Directed [31] = '{
      '{CH_COMMA, 1'b0, 1'b1, '{KIND_FEND, 8'h00, 16'd0, 1'b0, 1'b1}},
      '{CH_VT,    1'b0, 1'b0, NoTok},
      '{8'h00,    1'b0, 1'b1, '{KIND_DATA, 8'h00, 16'd0, 1'b0, 1'b1}},
      '{8'hFF,    1'b0, 1'b1, '{KIND_DATA, 8'hFF, 16'd0, 1'b0, 1'b1}},
      '{CH_SPACE, 1'b0, 1'b0, NoTok},
      '{CH_TAB,   1'b0, 1'b0, NoTok},
      '{8'h61,    1'b0, 1'b0, NoTok},
      '{CH_SPACE, 1'b1, 1'b0, NoTok},
      '{CH_CR,    1'b0, 1'b0, NoTok},
      '{CH_COMMA, 1'b0, 1'b0, NoTok},
      '{CH_LF,    1'b1, 1'b1, '{KIND_REC, 8'h00, 16'd0, 1'b0, 1'b1}},
      '{CH_QUOTE, 1'b0, 1'b0, NoTok},
      '{CH_COMMA, 1'b0, 1'b0, NoTok},
      '{CH_QUOTE, 1'b0, 1'b0, NoTok},
      '{CH_QUOTE, 1'b0, 1'b0, NoTok},
      '{CH_QUOTE, 1'b0, 1'b0, NoTok},
      '{8'h78,    1'b1, 1'b0, NoTok},
      '{CH_QUOTE, 1'b0, 1'b0, NoTok},
      '{8'h71,    1'b0, 1'b0, NoTok},
      '{CH_QUOTE, 1'b1, 1'b0, NoTok},
      '{8'h62,    1'b0, 1'b0, NoTok},
      '{CH_SPACE, 1'b0, 1'b0, NoTok},
      '{CH_TAB,   1'b0, 1'b0, NoTok},
      '{CH_VT,    1'b0, 1'b0, NoTok},
      '{CH_FF,    1'b0, 1'b0, NoTok},
      '{CH_SPACE, 1'b0, 1'b0, NoTok},
      '{CH_TAB,   1'b0, 1'b0, NoTok},
      '{CH_VT,    1'b0, 1'b0, NoTok},
      '{CH_FF,    1'b0, 1'b0, NoTok},
      '{CH_SPACE, 1'b0, 1'b0, NoTok},
      '{8'h63,    1'b1, 1'b0, NoTok}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch = 8'h00;
   logic        req_last_in_line = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_column_count;
   logic        rsp_ws_overflow;
   logic        rsp_last;

   csv_line_field_parser_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .req_last_in_line (req_last_in_line),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_column_count (rsp_column_count),
      .rsp_ws_overflow  (rsp_ws_overflow),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser state mirror
   logic        in_quote;
   logic        quote_open;
   logic        field_quoted;
   logic        line_blank;
   logic        field_started;
   logic        skip_rest;
   logic [7:0]  held_ws [WsDepth];
   int          held_cnt;
   logic [15:0] col_cnt;
   logic        ws_ovf;

   csv_token_type step_tokens [$];
   csv_token_type pending_tokens [$];
   csv_token_type typed_tok = '0;
   logic        typed_on = 1'b0;
   int          pred_n;

   int          mismatch_cnt = 0;
   int          token_cnt = 0;
   int          byte_cnt = 0;
   int          line_cnt = 0;
   int          burst_left = 0;
   logic [7:0]  line_buf [$];

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF;
   endfunction

   function automatic void reset_parser();
      in_quote      = 1'b0;
      quote_open    = 1'b0;
      field_quoted  = 1'b0;
      line_blank    = 1'b1;
      field_started = 1'b0;
      skip_rest     = 1'b0;
      held_cnt      = 0;
      col_cnt       = 16'd0;
      ws_ovf        = 1'b0;
   endfunction

   function automatic void put_token(input logic [1:0] k, input logic [7:0] d,
                                     input logic [15:0] c, input logic o);
      csv_token_type t;
      t.kind = k;
      t.data = d;
      t.cols = c;
      t.ovf  = o;
      t.last = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic void flush_held();
      for (int i = 0; i < held_cnt; i++) begin
         put_token(KIND_DATA, held_ws[i], 16'd0, 1'b0);
      end
      held_cnt = 0;
   endfunction

   function automatic void bump_cols();
      if (col_cnt != COL_MAX) begin
         col_cnt = col_cnt + 16'd1;
      end
   endfunction

   function automatic void plain_char(input logic [7:0] c);
      if (c == CH_LF || c == CH_CR) begin
         skip_rest = 1'b1;
      end else if (c == CH_QUOTE) begin
         flush_held();
         in_quote     = 1'b1;
         field_quoted = 1'b1;
         line_blank   = 1'b0;
      end else if (is_space(c) && !field_started) begin
         // drop leading whitespace
      end else if (c == CH_COMMA) begin
         held_cnt = 0;
         put_token(KIND_FEND, 8'h00, 16'd0, 1'b0);
         bump_cols();
         field_quoted  = 1'b0;
         field_started = 1'b0;
      end else begin
         line_blank    = 1'b0;
         field_started = 1'b1;
         if (is_space(c) && !field_quoted) begin
            if (held_cnt < WsDepth) begin
               held_ws[held_cnt] = c;
               held_cnt++;
            end else begin
               ws_ovf = 1'b1;
            end
         end else begin
            flush_held();
            put_token(KIND_DATA, c, 16'd0, 1'b0);
         end
      end
   endfunction

   function automatic int parse_byte(input logic [7:0] c, input logic fin);
      step_tokens.delete();
      if (skip_rest) begin
         // ignore bytes after a line break
      end else if (quote_open) begin
         quote_open = 1'b0;
         if (c == CH_QUOTE) begin
            put_token(KIND_DATA, CH_QUOTE, 16'd0, 1'b0);
            field_started = 1'b1;
         end else begin
            in_quote = 1'b0;
            plain_char(c);
         end
      end else if (in_quote) begin
         if (c == CH_QUOTE) begin
            quote_open = 1'b1;
         end else begin
            put_token(KIND_DATA, c, 16'd0, 1'b0);
            field_started = 1'b1;
         end
      end else begin
         plain_char(c);
      end
      if (fin) begin
         held_cnt = 0;
         if (!line_blank) begin
            put_token(KIND_FEND, 8'h00, 16'd0, 1'b0);
            bump_cols();
         end
         put_token(KIND_REC, 8'h00, col_cnt, ws_ovf);
         reset_parser();
      end
      if (step_tokens.size() > 0) begin
         step_tokens[step_tokens.size() - 1].last = 1'b1;
      end
      foreach (step_tokens[i]) begin
         pending_tokens.push_back(step_tokens[i]);
      end
      return step_tokens.size();
   endfunction

   task automatic check_token();
      csv_token_type got;
      csv_token_type exp;
      got = '{rsp_kind, rsp_data_byte, rsp_column_count, rsp_ws_overflow, rsp_last};
      token_cnt++;
      if (pending_tokens.size() == 0) begin
         mismatch_cnt++;
         if (mismatch_cnt <= 10) begin
            $display("unexpected response kind=%0d data=%02h cols=%0d ovf=%0b last=%0b",
                     got.kind, got.data, got.cols, got.ovf, got.last);
         end
      end else begin
         exp = pending_tokens.pop_front();
         if (got !== exp) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
               $display("mismatch at token %0d: exp kind=%0d data=%02h cols=%0d ovf=%0b last=%0b",
                        token_cnt, exp.kind, exp.data, exp.cols, exp.ovf, exp.last);
               $display("                     got kind=%0d data=%02h cols=%0d ovf=%0b last=%0b",
                        got.kind, got.data, got.cols, got.ovf, got.last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            check_token();
         end
         if (req_valid && !req_stall) begin
            pred_n = parse_byte(req_ch, req_last_in_line);
            if (typed_on) begin
               repeat (pred_n) void'(pending_tokens.pop_back());
               pending_tokens.push_back(typed_tok);
            end
         end
      end
   end

   // receiver stall pattern: quiet stretches, periodic, and random segments
   int seg_left = 0;
   int seg_mode = 0;
   int seg_period = 2;
   int seg_duty = 1;
   int seg_phase = 0;

   always @(negedge clock) begin
      if (seg_left == 0) begin
         seg_mode   = $urandom_range(0, 2);
         seg_left   = $urandom_range(20, 200);
         seg_period = $urandom_range(2, 9);
         seg_duty   = $urandom_range(1, seg_period - 1);
         seg_phase  = 0;
      end
      seg_left--;
      seg_phase = (seg_phase + 1) % seg_period;
      case (seg_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= (seg_phase < seg_duty);
         default: rsp_stall <= ($urandom_range(0, 2) == 0);
      endcase
   end

   task automatic send_byte(input logic [7:0] ch, input logic fin, input logic typed,
                            input csv_token_type tok);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      typed_on = typed;
      typed_tok = tok;
      req_valid <= 1'b1;
      req_ch <= ch;
      req_last_in_line <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end
      byte_cnt++;
      if (fin) begin
         line_cnt++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [7:0] text_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(33, 126));
      end while (c == CH_QUOTE || c == CH_COMMA);
      return c;
   endfunction

   function automatic logic [7:0] space_char();
      case ($urandom_range(0, 3))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_VT;
         default: return CH_FF;
      endcase
   endfunction

   function automatic void build_line();
      int nf;
      int tail;
      logic [7:0] c;
      line_buf.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(0, 3)) line_buf.push_back(space_char());
      end else begin
         nf = $urandom_range(1, 4);
         for (int f = 0; f < nf; f++) begin
            if (f > 0) begin
               line_buf.push_back(CH_COMMA);
            end
            case ($urandom_range(0, 9))
               0: begin
               end
               1, 2, 3, 4, 5: begin
                  repeat ($urandom_range(0, 2)) line_buf.push_back(space_char());
                  repeat ($urandom_range(1, 4)) begin
                     line_buf.push_back(text_char());
                     if ($urandom_range(0, 3) == 0) begin
                        line_buf.push_back(space_char());
                     end
                  end
                  tail = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 11)
                                                     : $urandom_range(0, 2);
                  repeat (tail) line_buf.push_back(space_char());
               end
               6, 7, 8: begin
                  repeat ($urandom_range(0, 1)) line_buf.push_back(space_char());
                  line_buf.push_back(CH_QUOTE);
                  repeat ($urandom_range(0, 4)) begin
                     case ($urandom_range(0, 5))
                        0: line_buf.push_back(text_char());
                        1: line_buf.push_back(CH_COMMA);
                        2: begin
                           line_buf.push_back(CH_QUOTE);
                           line_buf.push_back(CH_QUOTE);
                        end
                        3: line_buf.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
                        4: line_buf.push_back(space_char());
                        default: begin
                           c = 8'($urandom_range(0, 255));
                           line_buf.push_back(c);
                           if (c == CH_QUOTE) begin
                              line_buf.push_back(CH_QUOTE);
                           end
                        end
                     endcase
                  end
                  if ($urandom_range(0, 7) != 0) begin
                     line_buf.push_back(CH_QUOTE);
                     case ($urandom_range(0, 3))
                        1: line_buf.push_back(space_char());
                        2: line_buf.push_back(text_char());
                        3: line_buf.push_back(CH_QUOTE);
                        default: begin
                        end
                     endcase
                  end
               end
               default: begin
                  repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
               end
            endcase
         end
         if ($urandom_range(0, 5) == 0) begin
            line_buf.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
            repeat ($urandom_range(0, 2)) line_buf.push_back(8'($urandom_range(0, 255)));
         end
      end
      if (line_buf.size() == 0) begin
         line_buf.push_back(space_char());
      end
   endfunction

   initial begin
      int rand_bytes;
      logic paused;
      reset_parser();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (Directed[i]) begin
         send_byte(Directed[i].ch, Directed[i].fin, Directed[i].typed, Directed[i].tok);
      end
      drain();

      rand_bytes = 0;
      paused = 1'b0;
      while (rand_bytes < 300) begin
         build_line();
         foreach (line_buf[i]) begin
            send_byte(line_buf[i], i == line_buf.size() - 1, 1'b0, NoTok);
         end
         rand_bytes += line_buf.size();
         if (!paused && rand_bytes >= 150) begin
            drain();
            paused = 1'b1;
         end
      end

      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("run covered %0d lines, %0d request bytes and %0d checked tokens,",
               line_cnt, byte_cnt, token_cnt);
      $display("including quoting, line breaks and held whitespace overflow");
      if (mismatch_cnt == 0 && pending_tokens.size() == 0) begin
         $display("csv_line_field_parser_core verification clean");
      end else begin
         $display("%0d mismatches, %0d tokens outstanding", mismatch_cnt,
                  pending_tokens.size());
         $display("csv_line_field_parser_core verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d tokens outstanding", pending_tokens.size());
      $display("csv_line_field_parser_core verification failed");
      $finish;
   end

endmodule
